@@ hw/rtl/rmm_pkg.sv @@
// shared constants and types for the running median sorted cell row
package rmm_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // fixed field widths on the stream ports
    localparam int OP_W        = 1;
    localparam int IN_VALUE_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 2;

    localparam int S_FIELDS_W  = OP_W + IN_VALUE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = 2 * OUT_VALUE_W + COUNT_W + STATUS_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_ERASE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } rmm_cmd_t;

endpackage

@@ hw/rtl/running_median_multiset_top.sv @@
// top level: sorted multiset in a row of cells with running median read-out
//
// Keeps up to CAPACITY signed values in ascending order in a row of cells,
// one entry per cell. Each beat on the input inserts a value (op 0) or erases
// one copy of it (op 1); each produces one result beat with the lower and
// upper middle entries, the count and a status. The result is loaded after
// these steps in order: a compare in every cell against the broadcast
// value, one shift of the row by a single place, and the median select,
// which waits for a free output register. The store handles one item at a
// time, so a new item is accepted only once the result of the last one is
// loaded. A result waiting in the output register does not hold up the next
// item until that item needs the register. After reset the store is empty
// and ready at once.
module running_median_multiset_top #(
    parameter int CAPACITY   = rmm_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = rmm_pkg::DEF_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // op [0], value [32:1], zero fill above
    input  logic [rmm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // median_low [31:0], median_high [63:32], item_count [70:64],
    // status [72:71], zero fill above
    output logic [rmm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = rmm_pkg::M_TDATA_W - rmm_pkg::M_FIELDS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_SEL  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic op_reg;
    logic signed [VALUE_BITS-1:0] key_reg;
    logic [rmm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic out_valid_reg, out_valid_next;
    logic [rmm_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic signed [rmm_pkg::IN_VALUE_W-1:0] in_value;
    rmm_pkg::rmm_cmd_t cmd;

    logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_le;
    logic [CAPACITY-1:0] cell_eq;

    logic full;
    logic found;
    logic out_free;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
    logic signed [VALUE_BITS-1:0] lo_sel;
    logic signed [VALUE_BITS-1:0] hi_sel;
    logic signed [rmm_pkg::OUT_VALUE_W-1:0] lo_out;
    logic signed [rmm_pkg::OUT_VALUE_W-1:0] hi_out;

    assign in_value = s_axis_tdata[rmm_pkg::S_FIELDS_W-1:rmm_pkg::OP_W];
    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign found    = |cell_eq;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VALUE_BITS-1:0] l_val;
            logic signed [VALUE_BITS-1:0] r_val;
            logic l_valid;
            logic l_le;
            logic r_valid;

            if (g == 0) begin : g_first
                // nothing to the left: acts as a valid entry below every key
                assign l_val   = '0;
                assign l_valid = 1'b1;
                assign l_le    = 1'b1;
            end else begin : g_inner_l
                assign l_val   = cell_val[g-1];
                assign l_valid = cell_valid[g-1];
                assign l_le    = cell_le[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign r_val   = '0;
                assign r_valid = 1'b0;
            end else begin : g_inner_r
                assign r_val   = cell_val[g+1];
                assign r_valid = cell_valid[g+1];
            end

            rmm_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .key        (key_reg),
                .left_val   (l_val),
                .left_valid (l_valid),
                .left_le    (l_le),
                .right_val  (r_val),
                .right_valid(r_valid),
                .val        (cell_val[g]),
                .valid      (cell_valid[g]),
                .le         (cell_le[g]),
                .eq         (cell_eq[g])
            );
        end
    endgenerate

    // middle indexes of the updated row
    always_comb begin
        lo_idx = IDX_W'((cnt_reg - CNT_W'(1)) >> 1);
        hi_idx = IDX_W'(cnt_reg >> 1);
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lo_idx == IDX_W'(i)) begin
                lo_sel = lo_sel | cell_val[i];
            end
            if (hi_idx == IDX_W'(i)) begin
                hi_sel = hi_sel | cell_val[i];
            end
        end
        if (cnt_reg == '0) begin
            lo_out = '0;
            hi_out = '0;
        end else begin
            lo_out = rmm_pkg::OUT_VALUE_W'(lo_sel);
            hi_out = rmm_pkg::OUT_VALUE_W'(hi_sel);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd            = '0;

        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                status_next = rmm_pkg::STATUS_OK;
                if (op_reg == rmm_pkg::OP_INSERT) begin
                    if (full) begin
                        status_next = rmm_pkg::STATUS_FULL;
                    end else begin
                        cmd.ins  = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end else begin
                    if (found) begin
                        cmd.del  = 1'b1;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end else begin
                        status_next = rmm_pkg::STATUS_MISS;
                    end
                end
                state_next = ST_SEL;
            end
            ST_SEL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, status_reg,
                                      rmm_pkg::COUNT_W'(cnt_reg), hi_out, lo_out};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= rmm_pkg::STATUS_OK;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg  <= s_axis_tdata[0];
            key_reg <= VALUE_BITS'(in_value);
        end
    end

    // the stored count never passes the number of cells
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // between items the occupied cells match the count
    a_cnt_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(cell_valid) == int'(cnt_reg)))
        else $error("occupied cells disagree with count");

    // an accepted insert into a store with room grows it by exactly one
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && op_reg == rmm_pkg::OP_INSERT && !full)
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the store");

    // a result is only loaded when the previous one has left
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

@@ hw/rtl/rmm_cell.sv @@
// one cell of the sorted row: holds one entry and shifts with its neighbours
module rmm_cell #(
    parameter int VALUE_BITS = rmm_pkg::DEF_VALUE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rmm_pkg::rmm_cmd_t            cmd,
    input  logic signed [VALUE_BITS-1:0] key,
    input  logic signed [VALUE_BITS-1:0] left_val,
    input  logic                         left_valid,
    input  logic                         left_le,
    input  logic signed [VALUE_BITS-1:0] right_val,
    input  logic                         right_valid,
    output logic signed [VALUE_BITS-1:0] val,
    output logic                         valid,
    output logic                         le,
    output logic                         eq
);

    logic signed [VALUE_BITS-1:0] val_reg;
    logic                         valid_reg;
    logic                         le_reg;
    logic                         lt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            lt_reg    <= 1'b0;
        end else begin
            if (cmd.cmp) begin
                le_reg <= valid_reg && (val_reg <= key);
                lt_reg <= valid_reg && (val_reg < key);
            end
            if (cmd.ins && !le_reg) begin
                // first cell above the key takes it, the rest move up by one
                if (left_le) begin
                    valid_reg <= 1'b1;
                end else begin
                    valid_reg <= left_valid;
                end
            end
            if (cmd.del && !lt_reg) begin
                valid_reg <= right_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins && !le_reg) begin
            val_reg <= left_le ? key : left_val;
        end else if (cmd.del && !lt_reg) begin
            val_reg <= right_val;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;
    assign le    = le_reg;
    assign eq    = le_reg && !lt_reg;

endmodule
